// File: hw/rtl/gdve_pkg.sv
// Shared types and constants for the geometry delta varint encoder.
`default_nettype none

package gdve_pkg;

    // Command codes carried on s_tuser.
    localparam logic [1:0] CMD_ORIGIN = 2'd0;
    localparam logic [1:0] CMD_ELEM   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    // The remaining command value is unused; such requests are dropped.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVETO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINETO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

    localparam logic [7:0] MOVETO_RESET = 8'd1;
    localparam logic [7:0] LINETO_RESET = 8'd2;
    localparam logic [7:0] END_RESET    = 8'd0;

    // Varint groups: seven payload bits, bit 7 flags that more bytes follow.
    localparam int unsigned GROUP_BITS = 7;

    // Depth of the job queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Back-end serializer phases.
    typedef enum logic [1:0] {
        ST_HEAD,
        ST_X,
        ST_Y
    } state_t;

    // Control part of a queued job: a single byte, or a vertex that follows
    // its op byte with two varints.
    typedef struct packed {
        logic       vertex;
        logic [7:0] code;
    } job_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/gdve_front.sv
// Front part: configuration registers, command decode, origin and delta zigzag.
`default_nettype none

module gdve_front #(
    parameter int unsigned COORD_BITS = 40
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gdve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                       cfg_wdata,
    input  wire logic                             in_valid,
    input  wire logic [1:0]                       in_cmd,
    input  wire logic [7:0]                       in_op,
    input  wire logic signed [COORD_BITS-1:0]     in_x,
    input  wire logic signed [COORD_BITS-1:0]     in_y,
    output logic                                  in_ready,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output gdve_pkg::job_ctl_t                    q_ctl,
    output logic [COORD_BITS:0]                   q_zx,
    output logic [COORD_BITS:0]                   q_zy
);

    localparam int unsigned ZW = COORD_BITS + 1;

    logic [7:0] moveto_reg;
    logic [7:0] lineto_reg;
    logic [7:0] endcode_reg;
    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_y_reg;
    logic signed [COORD_BITS-1:0] origin_x_next;
    logic signed [COORD_BITS-1:0] origin_y_next;

    logic          accept;
    logic          is_vertex;
    logic          load_origin;
    logic [ZW-1:0] dx;
    logic [ZW-1:0] dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moveto_reg  <= gdve_pkg::MOVETO_RESET;
            lineto_reg  <= gdve_pkg::LINETO_RESET;
            endcode_reg <= gdve_pkg::END_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gdve_pkg::REG_MOVETO: moveto_reg  <= cfg_wdata;
                gdve_pkg::REG_LINETO: lineto_reg  <= cfg_wdata;
                gdve_pkg::REG_END:    endcode_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        is_vertex   = 1'b0;
        load_origin = 1'b0;
        q_push      = 1'b0;
        q_ctl       = '{vertex: 1'b0, code: in_op};
        case (in_cmd)
            gdve_pkg::CMD_ORIGIN: begin
                load_origin = accept;
            end
            gdve_pkg::CMD_ELEM: begin
                is_vertex   = (in_op == moveto_reg) || (in_op == lineto_reg);
                load_origin = accept && is_vertex;
                q_push      = accept;
                q_ctl       = '{vertex: is_vertex, code: in_op};
            end
            gdve_pkg::CMD_END: begin
                q_push = accept;
                q_ctl  = '{vertex: 1'b0, code: endcode_reg};
            end
            default: ;
        endcase
    end

    // Deltas are formed one bit wider than the coordinates so they never wrap.
    assign dx = {in_x[COORD_BITS-1], in_x} - {origin_x_reg[COORD_BITS-1], origin_x_reg};
    assign dy = {in_y[COORD_BITS-1], in_y} - {origin_y_reg[COORD_BITS-1], origin_y_reg};

    // Zigzag: shift left, flip every bit when negative.
    assign q_zx = {dx[ZW-2:0], 1'b0} ^ {ZW{dx[ZW-1]}};
    assign q_zy = {dy[ZW-2:0], 1'b0} ^ {ZW{dy[ZW-1]}};

    assign origin_x_next = load_origin ? in_x : origin_x_reg;
    assign origin_y_next = load_origin ? in_y : origin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gdve_queue.sv
// Short job queue between the front and back parts.
`default_nettype none

module gdve_queue #(
    parameter int unsigned WIDTH = 91,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn) push |-> !full
    ) else $error("queue written while full");

    a_no_pop_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn) pop |-> !empty
    ) else $error("queue read while empty");

    a_count_bound: assert property (
        @(posedge aclk) disable iff (!aresetn) count_reg <= CW'(DEPTH)
    ) else $error("queue count above depth");

endmodule

`default_nettype wire

// File: hw/rtl/gdve_back.sv
// Back part: serializes queued jobs into bytes through an output register.
`default_nettype none

module gdve_back #(
    parameter int unsigned COORD_BITS = 40
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  gdve_pkg::job_ctl_t       q_ctl,
    input  wire logic [COORD_BITS:0] q_zx,
    input  wire logic [COORD_BITS:0] q_zy,
    output logic                     q_pop,
    output logic                     out_valid,
    output logic [7:0]               out_byte,
    output logic                     out_last,
    input  wire logic                out_ready
);

    localparam int unsigned ZW = COORD_BITS + 1;
    localparam int unsigned GB = gdve_pkg::GROUP_BITS;

    gdve_pkg::state_t state_reg;
    gdve_pkg::state_t state_next;

    logic [ZW-1:0] zx_reg;
    logic [ZW-1:0] zy_reg;
    logic          valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    logic          advance;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_last;
    logic [ZW-1:0] zx_rest;
    logic [ZW-1:0] zy_rest;
    logic          x_more;
    logic          y_more;

    assign advance = !valid_reg || out_ready;
    assign zx_rest = zx_reg >> GB;
    assign zy_rest = zy_reg >> GB;
    assign x_more  = |zx_rest;
    assign y_more  = |zy_rest;

    // Output decode: what byte goes out this cycle and whether the head pops.
    always_comb begin
        emit      = 1'b0;
        emit_byte = q_ctl.code;
        emit_last = 1'b0;
        q_pop     = 1'b0;
        case (state_reg)
            gdve_pkg::ST_HEAD: begin
                emit      = advance && !q_empty;
                emit_byte = q_ctl.code;
                emit_last = !q_ctl.vertex;
                q_pop     = emit;
            end
            gdve_pkg::ST_X: begin
                emit      = advance;
                emit_byte = {x_more, zx_reg[GB-1:0]};
            end
            gdve_pkg::ST_Y: begin
                emit      = advance;
                emit_byte = {y_more, zy_reg[GB-1:0]};
                emit_last = !y_more;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gdve_pkg::ST_HEAD: begin
                if (emit && q_ctl.vertex) begin
                    state_next = gdve_pkg::ST_X;
                end
            end
            gdve_pkg::ST_X: begin
                if (emit && !x_more) begin
                    state_next = gdve_pkg::ST_Y;
                end
            end
            gdve_pkg::ST_Y: begin
                if (emit && !y_more) begin
                    state_next = gdve_pkg::ST_HEAD;
                end
            end
            default: state_next = gdve_pkg::ST_HEAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gdve_pkg::ST_HEAD;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= emit_byte;
            last_reg <= emit_last;
        end
        if (q_pop) begin
            zx_reg <= q_zx;
            zy_reg <= q_zy;
        end else if (emit && state_reg == gdve_pkg::ST_X) begin
            zx_reg <= zx_rest;
        end else if (emit && state_reg == gdve_pkg::ST_Y) begin
            zy_reg <= zy_rest;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    a_pop_only_at_head: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != gdve_pkg::ST_HEAD) |-> !q_pop
    ) else $error("queue popped in the middle of a vertex");

endmodule

`default_nettype wire

// File: hw/rtl/geometry_delta_varint_encoder.sv
// Top level of the geometry delta varint encoder: front, job queue and serializer.
// An item is written into the job queue, and its bytes then pass the output register.
// Throughput: one output byte per clock while m_tready allows; an item yields one byte
// for a plain op or end, 3 to 2*ceil((COORD_BITS+1)/7)+1 for a vertex.
// Set-origin items are taken and yield nothing; the four-entry queue sets slack.
// Reset (aresetn low, synchronous) empties the queue, zeroes the origin, restores codes.
`default_nettype none

module geometry_delta_varint_encoder #(
    parameter int unsigned COORD_BITS = 40
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration write port, no read-back.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [gdve_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [7:0]                           cfg_wdata,
    // Input stream.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // tdata, lowest bit up: op[7:0], x[COORD_BITS-1:0], y[COORD_BITS-1:0], zero fill.
    input  wire logic [((2*COORD_BITS+15)/8)*8-1:0]   s_tdata,
    // tuser: cmd[1:0].
    input  wire logic [1:0]                           s_tuser,
    // Output stream.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tdata: out_byte[7:0].
    output logic [7:0]                                m_tdata,
    // tlast: set on the final byte caused by one request.
    output logic                                      m_tlast
);

    localparam int unsigned ZW    = COORD_BITS + 1;
    localparam int unsigned CTL_W = $bits(gdve_pkg::job_ctl_t);
    localparam int unsigned JOB_W = CTL_W + 2 * ZW;

    // Field slices of the input request.
    logic [7:0]                   in_op;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;

    assign in_op = s_tdata[7:0];
    assign in_x  = s_tdata[8 +: COORD_BITS];
    assign in_y  = s_tdata[8 + COORD_BITS +: COORD_BITS];

    // Front to queue.
    logic               q_push;
    logic               q_full;
    gdve_pkg::job_ctl_t push_ctl;
    logic [ZW-1:0]      push_zx;
    logic [ZW-1:0]      push_zy;

    // Queue to back.
    logic               q_pop;
    logic               q_empty;
    logic [JOB_W-1:0]   head_data;
    gdve_pkg::job_ctl_t head_ctl;
    logic [ZW-1:0]      head_zx;
    logic [ZW-1:0]      head_zy;

    // The front decodes each request, forms the zigzagged deltas against the
    // running origin and moves the origin, all in the acceptance cycle.
    gdve_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_op     (in_op),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctl     (push_ctl),
        .q_zx      (push_zx),
        .q_zy      (push_zy)
    );

    // Jobs wait here so the front keeps taking requests while long vertices drain.
    gdve_queue #(
        .WIDTH (JOB_W),
        .DEPTH (gdve_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_ctl, push_zx, push_zy}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_ctl = head_data[JOB_W-1 -: CTL_W];
    assign head_zx  = head_data[2*ZW-1 -: ZW];
    assign head_zy  = head_data[ZW-1:0];

    // The back end emits the op byte straight from the queue head, then, for a vertex,
    // the x and y varints seven bits at a time, one byte per clock while m_tready allows.
    gdve_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_ctl     (head_ctl),
        .q_zx      (head_zx),
        .q_zy      (head_zy),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

endmodule

`default_nettype wire
